// ----- sv/abtt_pkg.sv -----
// Shared types and constants for the array binary tree traversal block.
`default_nettype none
package abtt_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 6;
  localparam int CHILD_W = IDX_W + 1;

  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_PREORDER  = 2'd1;
  localparam logic [1:0] CMD_INORDER   = 2'd2;
  localparam logic [1:0] CMD_POSTORDER = 2'd3;

  localparam logic [1:0] PH_LAST = 2'd2;

  localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic               rd_en;
    logic [CHILD_W-1:0] rd_addr;
  } store_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             none;
  } emit_t;

endpackage
`default_nettype wire

// ----- sv/array_binary_tree_traversal.sv -----
// Write: taken in idle, and the block stays ready for the next item. Traversal: accept in idle
// and a root fetch, then a step per frame phase plus a fetch per in-store child read for each
// node, and a flagged last result at the end. Output stalls hold the walk. The block takes no
// item while a traversal runs.
// Reset clears all node valid bits so every node reads empty, and empties the output.
`default_nettype none
module array_binary_tree_traversal #(
  parameter int LEVELS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // cmd[1:0], node_index[7:2], node_value[39:8]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // value[31:0]
  output logic             m_tlast,
  output logic             m_tuser    // none[0]
);

  abtt_pkg::store_req_t         req;
  logic                         rd_present;
  logic [abtt_pkg::VAL_W-1:0]   rd_data;
  logic                         out_free;
  logic                         emit_valid;
  abtt_pkg::emit_t              emit;

  assign out_free = !m_tvalid || m_tready;

  abtt_store #(
    .LEVELS(LEVELS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rd_present(rd_present),
    .rd_data   (rd_data)
  );

  abtt_walker #(
    .LEVELS(LEVELS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tdata[1:0]),
    .node_index(s_tdata[7:2]),
    .node_value(s_tdata[39:8]),
    .req       (req),
    .rd_present(rd_present),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .emit_valid(emit_valid),
    .emit      (emit)
  );

  // output register: hold a result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      m_tdata <= emit.value;
      m_tlast <= emit.last;
      m_tuser <= emit.none;
    end
  end

endmodule
`default_nettype wire

// ----- sv/abtt_store.sv -----
// Node store: one write and one registered read per cycle, per-entry valid bits.
`default_nettype none
module abtt_store #(
  parameter int LEVELS = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire abtt_pkg::store_req_t        req,
  output logic                             rd_present,
  output logic [abtt_pkg::VAL_W-1:0]       rd_data
);

  localparam int NODES = (1 << LEVELS) - 1;

  logic [abtt_pkg::VAL_W-1:0] mem [NODES];
  logic [NODES-1:0]           valid;
  logic                       rd_hit;
  logic                       wr_ok;
  logic                       rd_ok;

  assign wr_ok = req.wr_en && (req.wr_addr < abtt_pkg::IDX_W'(NODES));
  assign rd_ok = req.rd_addr < abtt_pkg::CHILD_W'(NODES);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[req.wr_addr[LEVELS-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[LEVELS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[req.wr_addr[LEVELS-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= rd_ok && valid[req.rd_addr[LEVELS-1:0]];
      end
    end
  end

  // never-written entries read as empty
  assign rd_present = rd_hit && (rd_data != abtt_pkg::EMPTY_MARK);

endmodule
`default_nettype wire

// ----- sv/abtt_walker.sv -----
// Traversal sequencer: frame stack, one store read per child, one-deep hold for the last flag.
`default_nettype none
module abtt_walker #(
  parameter int LEVELS = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  cmd,
  input  wire logic [abtt_pkg::IDX_W-1:0]  node_index,
  input  wire logic [abtt_pkg::VAL_W-1:0]  node_value,
  output abtt_pkg::store_req_t             req,
  input  wire logic                        rd_present,
  input  wire logic [abtt_pkg::VAL_W-1:0]  rd_data,
  input  wire logic                        out_free,
  output logic                             emit_valid,
  output abtt_pkg::emit_t                  emit
);

  localparam int NODES = (1 << LEVELS) - 1;
  localparam int SPW   = $clog2(LEVELS + 1);
  localparam int TW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                 state;
  logic [1:0]                 cmd_q;
  logic [SPW-1:0]             sp;
  logic [abtt_pkg::IDX_W-1:0] stk_idx [LEVELS];
  logic [1:0]                 stk_ph  [LEVELS];
  logic [abtt_pkg::VAL_W-1:0] stk_val [LEVELS];
  logic                       is_root;
  logic [abtt_pkg::IDX_W-1:0] child_q;
  logic                       pend_valid;
  logic                       pend_none;
  logic [abtt_pkg::VAL_W-1:0] pend_val;

  logic [TW-1:0]                top;
  logic [TW-1:0]                push_at;
  logic [abtt_pkg::IDX_W-1:0]   cur_idx;
  logic [1:0]                   cur_ph;
  logic [abtt_pkg::VAL_W-1:0]   cur_val;
  logic                         want_emit;
  logic                         stall;
  logic [abtt_pkg::CHILD_W-1:0] child;
  logic                         child_in;
  logic                         accept;

  assign top       = TW'(sp - SPW'(1));
  assign push_at   = TW'(sp);
  assign cur_idx   = stk_idx[top];
  assign cur_ph    = stk_ph[top];
  assign cur_val   = stk_val[top];
  assign want_emit = (cur_ph == 2'(cmd_q - 2'd1));
  assign stall     = want_emit && pend_valid && !out_free;
  assign child     = {cur_idx, 1'b0} + abtt_pkg::CHILD_W'(1) + abtt_pkg::CHILD_W'(cur_ph);
  assign child_in  = child < abtt_pkg::CHILD_W'(NODES);
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    req.wr_en   = accept && (cmd == abtt_pkg::CMD_WRITE);
    req.wr_addr = node_index;
    req.wr_data = node_value;
    req.rd_en   = 1'b0;
    req.rd_addr = '0;
    if (accept && (cmd != abtt_pkg::CMD_WRITE)) begin
      req.rd_en = 1'b1;
    end else if ((state == ST_STEP) && !stall && (cur_ph != abtt_pkg::PH_LAST) && child_in) begin
      req.rd_en   = 1'b1;
      req.rd_addr = child;
    end
  end

  always_comb begin
    emit_valid = 1'b0;
    emit.value = pend_val;
    emit.last  = 1'b0;
    emit.none  = 1'b0;
    case (state)
      ST_STEP: begin
        emit_valid = want_emit && pend_valid && out_free;
      end
      ST_DONE: begin
        emit_valid = out_free;
        emit.last  = 1'b1;
        emit.none  = pend_none;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sp         <= '0;
      pend_valid <= 1'b0;
      is_root    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (cmd != abtt_pkg::CMD_WRITE)) begin
            cmd_q      <= cmd;
            sp         <= '0;
            pend_valid <= 1'b0;
            is_root    <= 1'b1;
            child_q    <= '0;
            state      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (rd_present) begin
            if (sp < SPW'(LEVELS)) begin
              stk_idx[push_at] <= child_q;
              stk_ph[push_at]  <= 2'd0;
              stk_val[push_at] <= rd_data;
              sp               <= sp + SPW'(1);
            end
            state <= ST_STEP;
          end else if (is_root) begin
            // empty tree: one flagged result
            pend_val   <= '0;
            pend_none  <= 1'b1;
            pend_valid <= 1'b1;
            state      <= ST_DONE;
          end else begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!stall) begin
            if (want_emit) begin
              pend_val   <= cur_val;
              pend_none  <= 1'b0;
              pend_valid <= 1'b1;
            end
            if (cur_ph == abtt_pkg::PH_LAST) begin
              sp <= sp - SPW'(1);
              if (sp == SPW'(1)) begin
                state <= ST_DONE;
              end
            end else begin
              stk_ph[top] <= cur_ph + 2'd1;
              if (child_in) begin
                child_q <= abtt_pkg::IDX_W'(child);
                is_root <= 1'b0;
                state   <= ST_FETCH;
              end
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/array_binary_tree_traversal_test.sv -----
// Self-checking testbench for the array binary tree traversal block.
`default_nettype none
module array_binary_tree_traversal_test;
  timeunit 1ns;
  timeprecision 1ps;
  import abtt_pkg::*;

  localparam int LEVELS       = 6;
  localparam int NODES        = (1 << LEVELS) - 1;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS  = 40;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // cmd[1:0], node_index[7:2], node_value[39:8]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // value[31:0]
  logic        m_tlast;
  logic        m_tuser;        // none[0]

  array_binary_tree_traversal #(.LEVELS(LEVELS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the node store and the walk results still owed by the block.
  logic [VAL_W-1:0] tree_copy [NODES];
  emit_t            walk_results [$];
  int               error_count = 0;

  int       burst_left = 0;
  bit       tx_valid_held = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic bit node_filled(input int idx);
    return idx < NODES && tree_copy[idx] != EMPTY_MARK;
  endfunction

  function automatic void predict_walk(input logic [1:0] order);
    logic [IDX_W-1:0] frame_idx [LEVELS];
    logic [1:0]       frame_phase [LEVELS];
    logic [1:0]       emit_phase;
    emit_t            walk_out [$];
    emit_t            item;
    int               depth;
    int               top;
    int               child;
    emit_phase = order - CMD_PREORDER;
    if (!node_filled(0)) begin
      item.value = '0;
      item.last  = 1'b1;
      item.none  = 1'b1;
      walk_results.push_back(item);
      return;
    end
    frame_idx[0]   = '0;
    frame_phase[0] = '0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      if (frame_phase[top] == emit_phase) begin
        item.value = tree_copy[frame_idx[top]];
        item.last  = 1'b0;
        item.none  = 1'b0;
        walk_out.push_back(item);
      end
      if (frame_phase[top] >= PH_LAST) begin
        depth--;
      end else begin
        child = 2 * int'(frame_idx[top]) + 1 + int'(frame_phase[top]);
        frame_phase[top] = frame_phase[top] + 2'd1;
        if (node_filled(child) && depth < LEVELS) begin
          frame_idx[depth]   = child[IDX_W-1:0];
          frame_phase[depth] = '0;
          depth++;
        end
      end
    end
    walk_out[walk_out.size()-1].last = 1'b1;
    foreach (walk_out[k]) walk_results.push_back(walk_out[k]);
  endfunction

  // Drive one command, hold it until the transaction completes, then predict.
  task automatic send_command(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {val, idx, cmd};
    tx_valid_held = 1;
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_WRITE) begin
      if (idx < NODES) tree_copy[idx] = val;
    end else begin
      predict_walk(cmd);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      tx_valid_held = 0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 5);
    end
  endtask

  // Hold off the sender until every owed result is back, then let the block settle.
  task automatic drain_results();
    if (tx_valid_held) begin
      s_tvalid <= 1'b0;
      tx_valid_held = 0;
    end
    do @(posedge clk); while (walk_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node(input int idx, input logic [VAL_W-1:0] val);
    send_command(CMD_WRITE, idx[IDX_W-1:0], val);
  endtask

  task automatic walk_all_orders();
    send_command(CMD_PREORDER, IDX_W'($urandom), $urandom);
    send_command(CMD_INORDER, IDX_W'($urandom), $urandom);
    send_command(CMD_POSTORDER, IDX_W'($urandom), $urandom);
  endtask

  task automatic test_empty_tree();
    walk_all_orders();
    // Index past the store is dropped, so the tree stays empty.
    write_node(NODES, 32'd5);
    send_command(CMD_INORDER, '1, '1);
    drain_results();
  endtask

  task automatic test_extreme_values();
    write_node(0, 32'h7FFF_FFFF);
    write_node(1, 32'h8000_0000);
    write_node(2, 32'h0000_0000);
    write_node(NODES - 1, 32'h1234_5678);   // hidden below empty nodes
    walk_all_orders();
    write_node(1, EMPTY_MARK);
    send_command(CMD_INORDER, '0, '0);
    // Right spine down to node 30, which brings the earlier write to node 62 into reach.
    write_node(6, 32'hFFFF_FFFE);
    write_node(14, 32'h0000_0001);
    write_node(30, 32'hAAAA_5555);
    send_command(CMD_POSTORDER, '0, '0);
    send_command(CMD_PREORDER, '1, '0);
    drain_results();
  endtask

  task automatic test_full_tree();
    logic [VAL_W-1:0] val;
    for (int i = 0; i < NODES; i++) begin
      val = $urandom;
      if (val == EMPTY_MARK) val = 32'h0;
      write_node(i, val);
    end
    walk_all_orders();
    drain_results();
  endtask

  function automatic int pick_growth_slot();
    bit reach [NODES];
    int slots [$];
    for (int i = 0; i < NODES; i++) begin
      reach[i] = node_filled(i) && (i == 0 || reach[(i - 1) / 2]);
      if (!node_filled(i) && (i == 0 || reach[(i - 1) / 2])) slots.push_back(i);
    end
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(0, slots.size() - 1)];
  endfunction

  function automatic logic [VAL_W-1:0] random_node_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_trees();
    int counted;
    int grow;
    int slot;
    int walks;
    int round;
    counted = 0;
    round = 0;
    while (counted < 200) begin
      // Drop the current tree now and then; deeper leftovers stay behind.
      if ($urandom_range(0, 2) == 0) begin
        write_node(0, EMPTY_MARK);
        counted++;
      end
      grow = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      repeat (grow) begin
        if ($urandom_range(0, 6) == 0) begin
          // Noise: any index, any value, including past the store and the empty mark.
          slot = $urandom_range(0, NODES);
          write_node(slot, ($urandom_range(0, 2) == 0) ? EMPTY_MARK : random_node_value());
          if (slot < NODES) counted++;
        end else begin
          slot = pick_growth_slot();
          if (slot >= 0) begin
            write_node(slot, random_node_value());
            counted++;
          end
        end
      end
      walks = $urandom_range(1, 3);
      repeat (walks) begin
        send_command(CMD_PREORDER + 2'($urandom_range(0, 2)), IDX_W'($urandom), $urandom);
        counted++;
      end
      round++;
      if (round % 12 == 0) drain_results();
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(10, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      default:   m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  emit_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (walk_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h last=%b none=%b",
                                  m_tdata, m_tlast, m_tuser));
      end else begin
        want = walk_results.pop_front();
        if (m_tdata !== want.value)
          report_mismatch($sformatf("value %h, want %h", m_tdata, want.value));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
        if (m_tuser !== want.none)
          report_mismatch($sformatf("none %b, want %b", m_tuser, want.none));
      end
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) tree_copy[i] = EMPTY_MARK;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_tree();
    test_extreme_values();
    test_full_tree();
    test_random_trees();
    drain_results();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", walk_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
